// ===== rtl/pcol_pkg.sv =====
// Package for the particle pair collision block: item types, codes, defaults.
// Used by particle_pair_collision; depends on nothing.
package pcol_pkg;

   localparam int MAX_PARTICLES_DEF = 256;
   localparam int FRAC_BITS_DEF     = 16;

   localparam int PCOL_CW   = 40;
   localparam int PCOL_SATW = PCOL_CW + 1;

   localparam logic [2:0] KIND_LOAD_A = 3'd0;
   localparam logic [2:0] KIND_LOAD_B = 3'd1;
   localparam logic [2:0] KIND_RUN    = 3'd2;
   localparam logic [2:0] KIND_READ_A = 3'd3;
   localparam logic [2:0] KIND_READ_B = 3'd4;

   localparam logic RESP_RUN  = 1'b0;
   localparam logic RESP_READ = 1'b1;

   localparam logic [1:0] CSR_COUNT_A     = 2'd0;
   localparam logic [1:0] CSR_COUNT_B     = 2'd1;
   localparam logic [1:0] CSR_CONTACT_DSQ = 2'd2;
   localparam logic [1:0] CSR_RESTITUTION = 2'd3;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   typedef struct packed {
      logic               response_kind;
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic [16:0]        hit_count;
      logic               coincident_flag;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [PCOL_SATW-1:0] v);
      logic same;
      same = (&v[PCOL_SATW-1:31]) | ~(|v[PCOL_SATW-1:31]);
      if (same) begin
         return v[31:0];
      end else if (v[PCOL_SATW-1]) begin
         return 32'sh80000000;
      end else begin
         return 32'sh7FFFFFFF;
      end
   endfunction

endpackage

// ===== rtl/particle_pair_collision.sv =====
// Particle pair collision top level: command sequencer, pair arithmetic, config.
// Depends on pcol_pkg and pcol_ram (position and velocity memories).
//
//  channel  ports                            direction
//  req      start, busy, req_data            in, accepted on start && !busy
//  rsp      rsp_valid, rsp_data              out, one-cycle strobe
//  csr      csr_we, csr_index, csr_wdata     in, written when csr_we
//
// Loads are written on acceptance and leave busy low. Reads hold busy for one cycle;
// the read state registers the result onto rsp_data. A run steps through every pair:
// a pair out of contact or coincident skips the arithmetic, a pair in contact runs
// the square root and divider iterations, and a pair that gets an impulse also writes
// back both velocities; the report is registered after the last pair. Reset clears
// control and counts and sets config defaults, not memories. The receiver cannot stall.
module particle_pair_collision #(
   parameter int MAX_PARTICLES = pcol_pkg::MAX_PARTICLES_DEF,
   parameter int FRAC_BITS     = pcol_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pcol_pkg::req_type req_data,
   output logic              rsp_valid,
   output pcol_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import pcol_pkg::*;

   localparam int DEPTH = 2 * MAX_PARTICLES;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(MAX_PARTICLES + 1);
   localparam int UW    = FRAC_BITS + 2;
   localparam int NW    = 32 + FRAC_BITS;
   localparam int DCW   = $clog2(NW);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_RDV  = 5'd1;
   localparam logic [4:0] ST_RA   = 5'd2;
   localparam logic [4:0] ST_RB   = 5'd3;
   localparam logic [4:0] ST_DIFF = 5'd4;
   localparam logic [4:0] ST_SQX  = 5'd5;
   localparam logic [4:0] ST_SQY  = 5'd6;
   localparam logic [4:0] ST_TEST = 5'd7;
   localparam logic [4:0] ST_SQRT = 5'd8;
   localparam logic [4:0] ST_DIV  = 5'd9;
   localparam logic [4:0] ST_DOTX = 5'd10;
   localparam logic [4:0] ST_DOTY = 5'd11;
   localparam logic [4:0] ST_CHK  = 5'd12;
   localparam logic [4:0] ST_MULM = 5'd13;
   localparam logic [4:0] ST_UPX  = 5'd14;
   localparam logic [4:0] ST_UPY  = 5'd15;
   localparam logic [4:0] ST_WRA  = 5'd16;
   localparam logic [4:0] ST_WRB  = 5'd17;
   localparam logic [4:0] ST_NEXT = 5'd18;

   logic [4:0]  state_ff, state_in;
   logic [8:0]  count_a_ff, count_b_ff;
   logic [31:0] cds_ff;
   logic [16:0] rest_ff;

   logic [CNTW-1:0] i_ff, i_in, j_ff, j_in, na, nb;
   logic [16:0]     hits_ff, hits_in;
   logic            flag_ff, flag_in;
   logic            oob_ff, oob_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic signed [31:0] pax_ff, pax_in, pay_ff, pay_in;
   logic signed [31:0] vax_ff, vax_in, vay_ff, vay_in, vbx_ff, vbx_in, vby_ff, vby_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [32:0] rvx_ff, rvx_in, rvy_ff, rvy_in;
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [4:0]         sit_ff, sit_in;
   logic [31:0]        d_ff, d_in;
   logic [31:0]        remx_ff, remx_in, remy_ff, remy_in;
   logic [NW-1:0]      quox_ff, quox_in, quoy_ff, quoy_in;
   logic [DCW-1:0]     dit_ff, dit_in;
   logic signed [UW-1:0]    ux_ff, ux_in, uy_ff, uy_in;
   logic signed [UW+32:0]   dotx_ff, dotx_in;
   logic signed [PCOL_CW-1:0] c_ff, c_in, m_ff, m_in, upx_ff, upx_in, upy_ff, upy_in;

   logic          pos_we, vel_we;
   logic [AW-1:0] wr_addr, rd_addr, a_addr, b_addr, req_slot;
   logic [63:0]   pos_wdata, vel_wdata, pos_rdata, vel_rdata;

   logic [31:0] adx, ady;
   logic signed [UW+32:0]      dyp;
   logic signed [UW+33:0]      dsum;
   logic [17:0]                kval;
   logic signed [PCOL_CW+18:0] mprod;
   logic signed [UW+PCOL_CW-1:0] uprod;
   logic [63:0]  trial;
   logic [32:0]  tx, ty;
   logic         accept, req_oob, req_b;

   pcol_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_pos_ram (
      .clock(clock), .wr_en(pos_we), .wr_addr(wr_addr), .wr_data(pos_wdata),
      .rd_addr(rd_addr), .rd_data(pos_rdata)
   );

   pcol_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_vel_ram (
      .clock(clock), .wr_en(vel_we), .wr_addr(wr_addr), .wr_data(vel_wdata),
      .rd_addr(rd_addr), .rd_data(vel_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign na = (32'(count_a_ff) > MAX_PARTICLES) ? CNTW'(MAX_PARTICLES) : CNTW'(count_a_ff);
   assign nb = (32'(count_b_ff) > MAX_PARTICLES) ? CNTW'(MAX_PARTICLES) : CNTW'(count_b_ff);
   assign a_addr   = AW'(i_ff);
   assign b_addr   = AW'(j_ff) + AW'(MAX_PARTICLES);
   assign req_oob  = (32'(req_data.index) >= MAX_PARTICLES);
   assign req_b    = (req_data.kind == KIND_LOAD_B) || (req_data.kind == KIND_READ_B);
   assign req_slot = AW'(req_data.index) + (req_b ? AW'(MAX_PARTICLES) : AW'(0));

   assign adx   = dx_ff[31] ? 32'(-dx_ff) : 32'(dx_ff);
   assign ady   = dy_ff[31] ? 32'(-dy_ff) : 32'(dy_ff);
   assign dyp   = (UW+33)'(uy_ff) * (UW+33)'(rvy_ff);
   assign dsum  = (UW+34)'(dotx_ff) + (UW+34)'(dyp);
   assign kval  = 18'(rest_ff) + 18'd65536;
   assign mprod = (PCOL_CW+19)'(c_ff) * (PCOL_CW+19)'($signed({1'b0, kval}));
   assign uprod = (UW+PCOL_CW)'((state_ff == ST_UPX) ? ux_ff : uy_ff) * (UW+PCOL_CW)'(m_ff);
   assign trial = root_ff + bit_ff;
   assign tx    = {remx_ff, quox_ff[NW-1]};
   assign ty    = {remy_ff, quoy_ff[NW-1]};

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;  j_in = j_ff;
      hits_in = hits_ff;  flag_in = flag_ff;  oob_in = oob_ff;
      rsp_valid_in = 1'b0;  rsp_in = rsp_ff;
      pax_in = pax_ff;  pay_in = pay_ff;
      vax_in = vax_ff;  vay_in = vay_ff;  vbx_in = vbx_ff;  vby_in = vby_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  rvx_in = rvx_ff;  rvy_in = rvy_ff;
      sq_in = sq_ff;  rem_in = rem_ff;  root_in = root_ff;  bit_in = bit_ff;
      sit_in = sit_ff;  d_in = d_ff;
      remx_in = remx_ff;  remy_in = remy_ff;  quox_in = quox_ff;  quoy_in = quoy_ff;
      dit_in = dit_ff;  ux_in = ux_ff;  uy_in = uy_ff;  dotx_in = dotx_ff;
      c_in = c_ff;  m_in = m_ff;  upx_in = upx_ff;  upy_in = upy_ff;
      pos_we = 1'b0;  vel_we = 1'b0;
      wr_addr = req_slot;  rd_addr = req_slot;
      pos_wdata = {req_data.pos_x, req_data.pos_y};
      vel_wdata = {req_data.vel_x, req_data.vel_y};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_LOAD_A, KIND_LOAD_B: begin
                     pos_we = !req_oob;
                     vel_we = !req_oob;
                  end
                  KIND_RUN: begin
                     i_in = '0;  j_in = '0;  hits_in = '0;  flag_in = 1'b0;
                     if (na == '0 || nb == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{RESP_RUN, 32'sd0, 32'sd0, 17'd0, 1'b0};
                     end else begin
                        state_in = ST_RA;
                     end
                  end
                  KIND_READ_A, KIND_READ_B: begin
                     oob_in = req_oob;
                     state_in = ST_RDV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RDV: begin
            rsp_valid_in = 1'b1;
            rsp_in.response_kind   = RESP_READ;
            rsp_in.out_vel_x       = oob_ff ? 32'sd0 : vel_rdata[63:32];
            rsp_in.out_vel_y       = oob_ff ? 32'sd0 : vel_rdata[31:0];
            rsp_in.hit_count       = '0;
            rsp_in.coincident_flag = 1'b0;
            state_in = ST_IDLE;
         end
         ST_RA: begin
            rd_addr = a_addr;
            state_in = ST_RB;
         end
         ST_RB: begin
            rd_addr = b_addr;
            pax_in = pos_rdata[63:32];  pay_in = pos_rdata[31:0];
            vax_in = vel_rdata[63:32];  vay_in = vel_rdata[31:0];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dx_in  = sat32(PCOL_SATW'(pax_ff) - PCOL_SATW'($signed(pos_rdata[63:32])));
            dy_in  = sat32(PCOL_SATW'(pay_ff) - PCOL_SATW'($signed(pos_rdata[31:0])));
            vbx_in = vel_rdata[63:32];  vby_in = vel_rdata[31:0];
            rvx_in = 33'(vax_ff) - 33'($signed(vel_rdata[63:32]));
            rvy_in = 33'(vay_ff) - 33'($signed(vel_rdata[31:0]));
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sq_in = 64'(adx) * 64'(adx);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in = sq_ff + 64'(ady) * 64'(ady);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!(sq_ff < (64'(cds_ff) << FRAC_BITS))) begin
               state_in = ST_NEXT;
            end else if (sq_ff == '0) begin
               flag_in = 1'b1;
               state_in = ST_NEXT;
            end else begin
               rem_in = sq_ff;  root_in = '0;  bit_in = 64'd1 << 62;  sit_in = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            sit_in = sit_ff + 5'd1;
            if (sit_ff == 5'd31) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (dit_ff == DCW'(NW - 1) && sit_ff == 5'd0) begin
               d_in = root_ff[31:0];
               remx_in = '0;  remy_in = '0;
               quox_in = {adx, {FRAC_BITS{1'b0}}};
               quoy_in = {ady, {FRAC_BITS{1'b0}}};
               sit_in = 5'd1;
               dit_in = DCW'(NW - 1);
            end else begin
               if (tx >= 33'(d_ff)) begin
                  remx_in = 32'(tx - 33'(d_ff));
                  quox_in = {quox_ff[NW-2:0], 1'b1};
               end else begin
                  remx_in = tx[31:0];
                  quox_in = {quox_ff[NW-2:0], 1'b0};
               end
               if (ty >= 33'(d_ff)) begin
                  remy_in = 32'(ty - 33'(d_ff));
                  quoy_in = {quoy_ff[NW-2:0], 1'b1};
               end else begin
                  remy_in = ty[31:0];
                  quoy_in = {quoy_ff[NW-2:0], 1'b0};
               end
               dit_in = dit_ff - DCW'(1);
               if (dit_ff == '0) begin
                  sit_in = 5'd0;
                  dit_in = DCW'(NW - 1);
                  state_in = ST_DOTX;
               end
            end
         end
         ST_DOTX: begin
            ux_in = dx_ff[31] ? -$signed({1'b0, quox_ff[UW-2:0]})
                              :  $signed({1'b0, quox_ff[UW-2:0]});
            uy_in = dy_ff[31] ? -$signed({1'b0, quoy_ff[UW-2:0]})
                              :  $signed({1'b0, quoy_ff[UW-2:0]});
            dotx_in = (UW+33)'(ux_in) * (UW+33)'(rvx_ff);
            state_in = ST_DOTY;
         end
         ST_DOTY: begin
            c_in = PCOL_CW'(dsum >>> FRAC_BITS);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = c_ff[PCOL_CW-1] ? ST_MULM : ST_NEXT;
         end
         ST_MULM: begin
            m_in = PCOL_CW'(mprod >>> 16);
            state_in = ST_UPX;
         end
         ST_UPX: begin
            upx_in = PCOL_CW'(uprod >>> FRAC_BITS);
            state_in = ST_UPY;
         end
         ST_UPY: begin
            upy_in = PCOL_CW'(uprod >>> FRAC_BITS);
            state_in = ST_WRA;
         end
         ST_WRA: begin
            vel_we = 1'b1;
            wr_addr = a_addr;
            vel_wdata = {sat32(PCOL_SATW'(vax_ff) - PCOL_SATW'(upx_ff)),
                         sat32(PCOL_SATW'(vay_ff) - PCOL_SATW'(upy_ff))};
            state_in = ST_WRB;
         end
         ST_WRB: begin
            vel_we = 1'b1;
            wr_addr = b_addr;
            vel_wdata = {sat32(PCOL_SATW'(vbx_ff) + PCOL_SATW'(upx_ff)),
                         sat32(PCOL_SATW'(vby_ff) + PCOL_SATW'(upy_ff))};
            hits_in = hits_ff + 17'd1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_RA;
            if (j_ff + CNTW'(1) < nb) begin
               j_in = j_ff + CNTW'(1);
            end else begin
               j_in = '0;
               if (i_ff + CNTW'(1) < na) begin
                  i_in = i_ff + CNTW'(1);
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{RESP_RUN, 32'sd0, 32'sd0, hits_ff, flag_ff};
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_a_ff   <= 9'd0;
         count_b_ff   <= 9'd0;
         cds_ff       <= 32'd655;
         rest_ff      <= 17'd19661;
         i_ff <= '0;  j_ff <= '0;  hits_ff <= '0;  flag_ff <= 1'b0;  oob_ff <= 1'b0;
         sit_ff <= '0;  dit_ff <= DCW'(NW - 1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff <= i_in;  j_ff <= j_in;  hits_ff <= hits_in;  flag_ff <= flag_in;
         oob_ff <= oob_in;  sit_ff <= sit_in;  dit_ff <= dit_in;
         if (csr_we) begin
            case (csr_index)
               CSR_COUNT_A:     count_a_ff <= csr_wdata[8:0];
               CSR_COUNT_B:     count_b_ff <= csr_wdata[8:0];
               CSR_CONTACT_DSQ: cds_ff     <= csr_wdata;
               CSR_RESTITUTION: rest_ff    <= csr_wdata[16:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      pax_ff <= pax_in;  pay_ff <= pay_in;
      vax_ff <= vax_in;  vay_ff <= vay_in;  vbx_ff <= vbx_in;  vby_ff <= vby_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  rvx_ff <= rvx_in;  rvy_ff <= rvy_in;
      sq_ff <= sq_in;  rem_ff <= rem_in;  root_ff <= root_in;  bit_ff <= bit_in;
      d_ff <= d_in;  remx_ff <= remx_in;  remy_ff <= remy_in;
      quox_ff <= quox_in;  quoy_ff <= quoy_in;
      ux_ff <= ux_in;  uy_ff <= uy_in;  dotx_ff <= dotx_in;
      c_ff <= c_in;  m_ff <= m_in;  upx_ff <= upx_in;  upy_ff <= upy_in;
   end

   a_run_zero_vel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.response_kind == RESP_RUN) |->
         (rsp_data.out_vel_x == 32'sd0 && rsp_data.out_vel_y == 32'sd0))
      else $error("run report carries velocity data");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> $onehot(bit_ff))
      else $error("square root bit lost");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && sit_ff != 5'd0) |-> (remx_ff < d_ff && remy_ff < d_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== rtl/pcol_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module pcol_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
